// File: design/ray_triangle_intersect_defines.svh
// Assertion macros shared by the ray/triangle intersection RTL.
`ifndef RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RTI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RTI_ASSERT(lbl, prop, msg)
`define RTI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: design/rti_pkg.sv
// Types and constants of the ray/triangle intersection block.
`default_nettype none
package rti_pkg;
  localparam int CoordW    = 20;
  localparam int EdgeW     = 21;
  localparam int CrossW    = 42;
  localparam int HW        = 31;
  localparam int QW        = 32;
  localparam int DotW      = 56;
  localparam int MagW      = 55;
  localparam int RemW      = 86;
  localparam int DivBits   = 31;
  localparam int TW        = 32;
  localparam int NormW     = 16;
  localparam int MatW      = 8;
  localparam int CfgW      = 60;
  localparam int ScaleW    = 30;
  localparam int SatShift  = 15;
  localparam int FracBits  = 16;
  localparam int NormSteps = 15;
  localparam int SqrtSteps = 32;
  localparam int RayLatency = 41;

  localparam logic signed [DotW-1:0] EpsPos = DotW'(10);
  localparam logic signed [DotW-1:0] EpsNeg = -EpsPos;
  localparam logic signed [TW-1:0]   TMax   = 32'sh7FFF_FFFF;
  localparam logic signed [TW-1:0]   TMin   = 32'sh8000_0000;
  localparam logic signed [36:0]     PtMax  = 37'sd524287;
  localparam logic signed [36:0]     PtMin  = -37'sd524288;

  typedef enum logic [1:0] {
    CFG_VERTEX_ZERO, CFG_VERTEX_ONE, CFG_VERTEX_TWO, CFG_MATERIAL
  } cfg_index_t;

  typedef enum logic [3:0] {
    PC_IDLE, PC_EDGE, PC_MUL, PC_CROSS, PC_SCALE, PC_SQUARE, PC_SUM, PC_SQRT, PC_DIV
  } pc_state_t;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic signed [CoordW-1:0] origin_z;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] dir_z;
    logic signed [TW-1:0]     t_lower;
    logic signed [TW-1:0]     t_upper;
  } ray_req_t;

  typedef struct packed {
    logic                     hit_found;
    logic signed [TW-1:0]     t_hit;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic signed [NormW-1:0]  normal_x;
    logic signed [NormW-1:0]  normal_y;
    logic signed [NormW-1:0]  normal_z;
    logic [MatW-1:0]          hit_material;
  } ray_res_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vec_t;

  // control and ray data that ride along the pipeline
  typedef struct packed {
    logic                 valid;
    logic                 miss;
    logic                 flip;
    vec_t                 o;
    vec_t                 d;
    logic signed [TW-1:0] tlo;
    logic signed [TW-1:0] thi;
  } carry_t;
endpackage
`default_nettype wire

// File: design/ray_triangle_intersect.sv
// Moller-Trumbore ray/triangle intersection, fully pipelined.
//
//  channel  | signals                          | handshake
//  request  | start, busy, request             | taken when start && !busy
//  result   | done, result                     | one-cycle strobe, no back-pressure
//  config   | cfg_we, cfg_index, cfg_data      | written when cfg_we is high
//
// One request per cycle while busy is low; each passes the dot-product stages,
// the 31-stage restoring divider for t and the stages that form the result.
// A vertex write starts a triangle setup (edges, face normal via a 32-step
// square root and 15-step divides); busy is high during it.
// Reset is synchronous; it clears the triangle, setup state and valid bits.
// The pipeline never stalls.
`default_nettype none
`include "ray_triangle_intersect_defines.svh"
module ray_triangle_intersect (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire rti_pkg::ray_req_t   request,
  output logic                     done,
  output rti_pkg::ray_res_t        result,
  input  wire logic                cfg_we,
  input  wire rti_pkg::cfg_index_t cfg_index,
  input  wire logic [59:0]         cfg_data
);
  import rti_pkg::*;

  typedef struct packed {
    carry_t            c;
    logic              sat;
    logic              neg;
    logic [RemW-1:0]   r;
    logic [MagW-1:0]   d;
    logic [DivBits-1:0] q;
  } div_stage_t;

  // configuration registers
  logic [CfgW-1:0] vtx0, vtx1, vtx2;
  logic [MatW-1:0] mat_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx0   <= '0;
      vtx1   <= '0;
      vtx2   <= '0;
      mat_id <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERTEX_ZERO: vtx0 <= cfg_data;
        CFG_VERTEX_ONE:  vtx1 <= cfg_data;
        CFG_VERTEX_TWO:  vtx2 <= cfg_data;
        CFG_MATERIAL:    mat_id <= cfg_data[MatW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [CoordW-1:0] v0c [3];
  logic signed [CoordW-1:0] v1c [3];
  logic signed [CoordW-1:0] v2c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v0c[i] = vtx0[i*CoordW +: CoordW];
      v1c[i] = vtx1[i*CoordW +: CoordW];
      v2c[i] = vtx2[i*CoordW +: CoordW];
    end
  end

  // ---------------------------------------------------------------
  // triangle setup sequencer
  // ---------------------------------------------------------------
  pc_state_t pc_state, pc_state_next;
  logic [4:0] pc_cnt;
  logic       vtx_write;

  assign vtx_write = cfg_we && (cfg_index != CFG_MATERIAL);
  assign busy      = (pc_state != PC_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc_state <= PC_IDLE;
      pc_cnt   <= '0;
    end else begin
      pc_state <= pc_state_next;
      pc_cnt   <= (pc_state_next == pc_state) ? pc_cnt + 5'd1 : '0;
    end
  end

  always_comb begin
    pc_state_next = pc_state;
    case (pc_state)
      PC_IDLE:   pc_state_next = PC_IDLE;
      PC_EDGE:   pc_state_next = PC_MUL;
      PC_MUL:    pc_state_next = PC_CROSS;
      PC_CROSS:  pc_state_next = PC_SCALE;
      PC_SCALE:  pc_state_next = PC_SQUARE;
      PC_SQUARE: pc_state_next = PC_SUM;
      PC_SUM:    pc_state_next = PC_SQRT;
      PC_SQRT:   if (pc_cnt == 5'(SqrtSteps - 1)) pc_state_next = PC_DIV;
      PC_DIV:    if (pc_cnt == 5'(NormSteps - 1)) pc_state_next = PC_IDLE;
      default:   pc_state_next = PC_IDLE;
    endcase
    if (vtx_write) pc_state_next = PC_EDGE;
  end

  logic signed [EdgeW-1:0]  e1 [3];
  logic signed [EdgeW-1:0]  e2 [3];
  logic signed [CrossW-1:0] cp [6];
  logic signed [CrossW-1:0] nc [3];
  logic [ScaleW-1:0]        m_mag [3];
  logic                     m_neg [3];
  logic [2*ScaleW-1:0]      sq [3];
  logic [63:0]              sx, sres, sbit, sroot_try;
  logic [32:0]              drem [3];
  logic [NormSteps-1:0]     dq [3];
  logic signed [NormW-1:0]  nn [3];

  // magnitude scaling of the cross product
  logic [CrossW-2:0] ax [3];
  logic [CrossW-2:0] orv;
  logic [3:0]        kshift;

  always_comb begin
    orv = '0;
    for (int i = 0; i < 3; i++) begin
      ax[i] = nc[i][CrossW-1] ? (CrossW-1)'(-nc[i]) : (CrossW-1)'(nc[i]);
      orv   = orv | ax[i];
    end
    kshift = '0;
    for (int b = 0; b < CrossW - 1 - ScaleW; b++) begin
      if (orv[ScaleW+b]) kshift = 4'(b + 1);
    end
  end

  // normal divide lanes: m * 16384 / len, one quotient bit per cycle
  logic [32:0]          len33;
  logic [32:0]          rt [3];
  logic [32:0]          rn [3];
  logic [NormSteps-1:0] qn [3];

  assign sroot_try = sres + sbit;
  assign len33     = 33'(sres);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rt[i] = (pc_cnt == '0) ? drem[i] : (drem[i] << 1);
      if (rt[i] >= len33) begin
        rn[i] = rt[i] - len33;
        qn[i] = {dq[i][NormSteps-2:0], 1'b1};
      end else begin
        rn[i] = rt[i];
        qn[i] = {dq[i][NormSteps-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= '0;
        e2[i] <= '0;
        nn[i] <= '0;
      end
    end else begin
      case (pc_state)
        PC_EDGE: begin
          for (int i = 0; i < 3; i++) begin
            e1[i] <= EdgeW'(v1c[i]) - EdgeW'(v0c[i]);
            e2[i] <= EdgeW'(v2c[i]) - EdgeW'(v0c[i]);
          end
        end
        PC_MUL: begin
          cp[0] <= e1[1] * e2[2];
          cp[1] <= e1[2] * e2[1];
          cp[2] <= e1[2] * e2[0];
          cp[3] <= e1[0] * e2[2];
          cp[4] <= e1[0] * e2[1];
          cp[5] <= e1[1] * e2[0];
        end
        PC_CROSS: begin
          nc[0] <= cp[0] - cp[1];
          nc[1] <= cp[2] - cp[3];
          nc[2] <= cp[4] - cp[5];
        end
        PC_SCALE: begin
          for (int i = 0; i < 3; i++) begin
            m_mag[i] <= ScaleW'(ax[i] >> kshift);
            m_neg[i] <= nc[i][CrossW-1];
          end
        end
        PC_SQUARE: begin
          for (int i = 0; i < 3; i++) sq[i] <= m_mag[i] * m_mag[i];
        end
        PC_SUM: begin
          sx   <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
          sres <= '0;
          sbit <= 64'h4000_0000_0000_0000;
        end
        PC_SQRT: begin
          if (sx >= sroot_try) begin
            sx   <= sx - sroot_try;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          for (int i = 0; i < 3; i++) begin
            drem[i] <= 33'(m_mag[i]);
            dq[i]   <= '0;
          end
        end
        PC_DIV: begin
          for (int i = 0; i < 3; i++) begin
            drem[i] <= rn[i];
            dq[i]   <= qn[i];
            if (pc_cnt == 5'(NormSteps - 1)) begin
              if (sres == '0) nn[i] <= '0;
              else nn[i] <= m_neg[i] ? -NormW'(qn[i]) : NormW'(qn[i]);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // ray pipeline
  // ---------------------------------------------------------------
  logic accept;
  assign accept = start && !busy;

  carry_t st1, st2, st3, st4, st5, st6, stt, stm;
  logic signed [EdgeW-1:0] s1 [3];
  logic signed [EdgeW-1:0] s2 [3];
  logic signed [EdgeW-1:0] s3 [3];

  // stage 1: register the request, s = origin - v0
  always_ff @(posedge clk) begin
    if (rst) begin
      st1.valid <= 1'b0;
    end else begin
      st1.valid <= accept;
    end
    st1.miss <= 1'b0;
    st1.flip <= 1'b0;
    st1.o    <= '{x: request.origin_x, y: request.origin_y, z: request.origin_z};
    st1.d    <= '{x: request.dir_x, y: request.dir_y, z: request.dir_z};
    st1.tlo  <= request.t_lower;
    st1.thi  <= request.t_upper;
    s1[0]    <= EdgeW'(request.origin_x) - EdgeW'(v0c[0]);
    s1[1]    <= EdgeW'(request.origin_y) - EdgeW'(v0c[1]);
    s1[2]    <= EdgeW'(request.origin_z) - EdgeW'(v0c[2]);
  end

  // stage 2: cross product terms, normal-facing products
  logic signed [40:0] hp [6];
  logic signed [41:0] qp [6];
  logic signed [35:0] fp [3];

  always_ff @(posedge clk) begin
    if (rst) st2.valid <= 1'b0;
    else st2.valid <= st1.valid;
    st2.miss <= st1.miss;
    st2.flip <= st1.flip;
    st2.o    <= st1.o;
    st2.d    <= st1.d;
    st2.tlo  <= st1.tlo;
    st2.thi  <= st1.thi;
    s2       <= s1;
    hp[0] <= st1.d.y * e2[2];
    hp[1] <= st1.d.z * e2[1];
    hp[2] <= st1.d.z * e2[0];
    hp[3] <= st1.d.x * e2[2];
    hp[4] <= st1.d.x * e2[1];
    hp[5] <= st1.d.y * e2[0];
    qp[0] <= s1[1] * e1[2];
    qp[1] <= s1[2] * e1[1];
    qp[2] <= s1[2] * e1[0];
    qp[3] <= s1[0] * e1[2];
    qp[4] <= s1[0] * e1[1];
    qp[5] <= s1[1] * e1[0];
    fp[0] <= nn[0] * st1.d.x;
    fp[1] <= nn[1] * st1.d.y;
    fp[2] <= nn[2] * st1.d.z;
  end

  // stage 3: h = dir x e2, q = s x e1, floored by 2^10
  logic signed [40:0] hd [3];
  logic signed [41:0] qd [3];
  logic signed [37:0] fsum;
  logic signed [HW-1:0] h3 [3];
  logic signed [QW-1:0] q3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hd[i] = hp[2*i] - hp[2*i+1];
      qd[i] = qp[2*i] - qp[2*i+1];
    end
    fsum = 38'(fp[0]) + 38'(fp[1]) + 38'(fp[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) st3.valid <= 1'b0;
    else st3.valid <= st2.valid;
    st3.miss <= st2.miss;
    st3.flip <= (fsum > 38'sd0);
    st3.o    <= st2.o;
    st3.d    <= st2.d;
    st3.tlo  <= st2.tlo;
    st3.thi  <= st2.thi;
    s3       <= s2;
    for (int i = 0; i < 3; i++) begin
      h3[i] <= hd[i][40:10];
      q3[i] <= qd[i][41:10];
    end
  end

  // stage 4: dot-product terms
  logic signed [51:0] ap4 [3];
  logic signed [51:0] up4 [3];
  logic signed [51:0] vp4 [3];
  logic signed [52:0] tp4 [3];

  always_ff @(posedge clk) begin
    if (rst) st4.valid <= 1'b0;
    else st4.valid <= st3.valid;
    st4.miss <= st3.miss;
    st4.flip <= st3.flip;
    st4.o    <= st3.o;
    st4.d    <= st3.d;
    st4.tlo  <= st3.tlo;
    st4.thi  <= st3.thi;
    for (int i = 0; i < 3; i++) begin
      ap4[i] <= e1[i] * h3[i];
      up4[i] <= s3[i] * h3[i];
      tp4[i] <= e2[i] * q3[i];
    end
    vp4[0] <= st3.d.x * q3[0];
    vp4[1] <= st3.d.y * q3[1];
    vp4[2] <= st3.d.z * q3[2];
  end

  // stage 5: determinant and numerators
  logic signed [DotW-1:0] a5, nu5, nv5, nt5;

  always_ff @(posedge clk) begin
    if (rst) st5.valid <= 1'b0;
    else st5.valid <= st4.valid;
    st5.miss <= st4.miss;
    st5.flip <= st4.flip;
    st5.o    <= st4.o;
    st5.d    <= st4.d;
    st5.tlo  <= st4.tlo;
    st5.thi  <= st4.thi;
    a5  <= DotW'(ap4[0]) + DotW'(ap4[1]) + DotW'(ap4[2]);
    nu5 <= DotW'(up4[0]) + DotW'(up4[1]) + DotW'(up4[2]);
    nv5 <= DotW'(vp4[0]) + DotW'(vp4[1]) + DotW'(vp4[2]);
    nt5 <= DotW'(tp4[0]) + DotW'(tp4[1]) + DotW'(tp4[2]);
  end

  // stage 6: parallel and barycentric rejects, sign normalization
  logic signed [DotW-1:0] an, nun, nvn, ntn;
  logic                   miss6;
  logic [MagW-1:0]        n6, d6;
  logic                   neg6;
  logic [MagW-1:0]        n_mag_c;

  always_comb begin
    an  = a5[DotW-1] ? -a5  : a5;
    nun = a5[DotW-1] ? -nu5 : nu5;
    nvn = a5[DotW-1] ? -nv5 : nv5;
    ntn = a5[DotW-1] ? -nt5 : nt5;
    miss6 = ((a5 >= EpsNeg) && (a5 <= EpsPos)) || (nun < 0) || (nun > an) ||
            (nvn < 0) || ((nun + nvn) > an);
    n_mag_c = ntn[DotW-1] ? MagW'(-ntn) : MagW'(ntn);
  end

  always_ff @(posedge clk) begin
    if (rst) st6.valid <= 1'b0;
    else st6.valid <= st5.valid;
    st6.miss <= st5.miss || miss6;
    st6.flip <= st5.flip;
    st6.o    <= st5.o;
    st6.d    <= st5.d;
    st6.tlo  <= st5.tlo;
    st6.thi  <= st5.thi;
    n6       <= n_mag_c;
    d6       <= MagW'(an);
    neg6     <= ntn[DotW-1];
  end

  // t divider: one quotient bit of |nt| * 2^16 / a per stage
  div_stage_t      dv      [DivBits+1];
  div_stage_t      dv_next [DivBits+1];
  logic [RemW-1:0] dsh     [DivBits];

  always_comb begin
    dv_next[0].c   = st6;
    dv_next[0].neg = neg6;
    dv_next[0].d   = d6;
    dv_next[0].q   = '0;
    dv_next[0].r   = RemW'(n6) << FracBits;
    dv_next[0].sat = RemW'(n6) >= (RemW'(d6) << SatShift);
    for (int j = 0; j < DivBits; j++) begin
      dv_next[j+1] = dv[j];
      dsh[j] = RemW'(dv[j].d) << (DivBits - 1 - j);
      if (dv[j].r >= dsh[j]) begin
        dv_next[j+1].r = dv[j].r - dsh[j];
        dv_next[j+1].q[DivBits-1-j] = 1'b1;
      end
    end
    // reset clears the valid bits of every divider stage
    if (rst) begin
      for (int j = 0; j <= DivBits; j++) dv_next[j].c.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    dv <= dv_next;
  end

  // stage T: signed, saturated t and window test
  logic signed [TW-1:0] t_val, tt;
  logic [TW-1:0]        t_u;

  always_comb begin
    t_u = {1'b0, dv[DivBits].q};
    if (dv[DivBits].sat) t_val = dv[DivBits].neg ? TMin : TMax;
    else t_val = dv[DivBits].neg ? -t_u : t_u;
  end

  always_ff @(posedge clk) begin
    if (rst) stt.valid <= 1'b0;
    else stt.valid <= dv[DivBits].c.valid;
    stt.miss <= dv[DivBits].c.miss || (t_val < dv[DivBits].c.tlo) ||
                (t_val > dv[DivBits].c.thi);
    stt.flip <= dv[DivBits].c.flip;
    stt.o    <= dv[DivBits].c.o;
    stt.d    <= dv[DivBits].c.d;
    stt.tlo  <= dv[DivBits].c.tlo;
    stt.thi  <= dv[DivBits].c.thi;
    tt       <= t_val;
  end

  // stage M: t * dir
  logic signed [51:0]   pm [3];
  logic signed [TW-1:0] tm;

  always_ff @(posedge clk) begin
    if (rst) stm.valid <= 1'b0;
    else stm.valid <= stt.valid;
    stm.miss <= stt.miss;
    stm.flip <= stt.flip;
    stm.o    <= stt.o;
    stm.d    <= stt.d;
    stm.tlo  <= stt.tlo;
    stm.thi  <= stt.thi;
    tm       <= tt;
    pm[0]    <= tt * stt.d.x;
    pm[1]    <= tt * stt.d.y;
    pm[2]    <= tt * stt.d.z;
  end

  // output stage: saturated hit point, facing normal, zero on miss
  logic signed [35:0]       psh [3];
  logic signed [36:0]       psum [3];
  logic signed [CoordW-1:0] pt [3];
  logic signed [CoordW-1:0] oc [3];
  logic signed [NormW-1:0]  nf [3];

  always_comb begin
    oc[0] = stm.o.x;
    oc[1] = stm.o.y;
    oc[2] = stm.o.z;
    for (int i = 0; i < 3; i++) begin
      psh[i]  = pm[i][51:16];
      psum[i] = 37'(psh[i]) + 37'(oc[i]);
      if (psum[i] > PtMax) pt[i] = CoordW'(PtMax);
      else if (psum[i] < PtMin) pt[i] = CoordW'(PtMin);
      else pt[i] = CoordW'(psum[i]);
      nf[i] = stm.flip ? -nn[i] : nn[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= stm.valid;
    if (stm.miss) begin
      result <= '0;
    end else begin
      result.hit_found    <= 1'b1;
      result.t_hit        <= tm;
      result.point_x      <= pt[0];
      result.point_y      <= pt[1];
      result.point_z      <= pt[2];
      result.normal_x     <= nf[0];
      result.normal_y     <= nf[1];
      result.normal_z     <= nf[2];
      result.hit_material <= mat_id;
    end
  end

  // checks
  `RTI_ASSERT(a_latency, accept |-> ##RayLatency done, "request did not complete on time")
  `RTI_ASSERT(a_setup_busy, vtx_write |=> busy, "vertex write did not start setup")
  `RTI_ASSERT(a_miss_zero, done && !result.hit_found |-> result.t_hit == 0 && result.hit_material == '0, "miss result not cleared")
  `RTI_ASSERT(a_normal_range, done && result.hit_found |-> result.normal_x <= 16384 && result.normal_x >= -16384, "normal out of range")
  `RTI_ASSERT_ALWAYS(a_reset_quiet, rst |=> !done, "result strobe after reset")
endmodule
`default_nettype wire
